>>> rtl/srpg_pkg.sv
// Shared types and constants for the stepper ramp pulse generator.
// Used by every module of the block; depends on nothing else.
package srpg_pkg;

    localparam int RAMP_DEPTH_DEF = 256;
    localparam int STEP_BITS_DEF  = 24;

    localparam int ENTRIES_W  = 9;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 9'd256;
    localparam logic [DIV_W-1:0]     PERIOD_RESET  = 16'd1000;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TABLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENTRIES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DIVISOR = 1'b1;

    typedef enum logic [3:0] {
        PH_INIT   = 4'b0001,
        PH_ACCEL  = 4'b0010,
        PH_CRUISE = 4'b0100,
        PH_DECEL  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] step_count;
        logic [15:0] target_divisor;
        logic        direction;
        logic [7:0]  table_index;
        logic [15:0] table_value;
    } in_item_t;

    typedef struct packed {
        logic        pulse_level;
        logic        dir_level;
        logic        driver_enable;
        logic        motion_done;
        logic [15:0] current_divisor;
    } out_item_t;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [15:0] value;
    } tbl_wr_t;

    typedef struct packed {
        logic                 en;
        logic [ENTRIES_W-1:0] pos;
    } tbl_rd_t;

endpackage

>>> rtl/srpg_table_mem.sv
// Ramp table memory with one write port, one registered read port and a
// clearing sweep after reset. Depends on srpg_pkg.
module srpg_table_mem
    import srpg_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_wr_t          wr,
    input  tbl_rd_t          rd,
    output logic [DIV_W-1:0] rd_data,
    output logic             ready
);

    localparam int AW = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(RAMP_DEPTH - 1);

    logic [DIV_W-1:0] mem [RAMP_DEPTH];
    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    clr_next;
    logic             ready_reg;
    logic             ready_next;
    logic [DIV_W-1:0] rd_data_reg;

    logic [AW+7:0]           wr_wide;
    logic [AW+ENTRIES_W-1:0] rd_wide;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic                    wr_ok;

    assign wr_wide = {{AW{1'b0}}, wr.index};
    assign rd_wide = {{AW{1'b0}}, rd.pos};
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_ok   = wr.en && (32'(wr.index) < 32'(RAMP_DEPTH));

    always_comb
    begin
        clr_next   = clr_reg;
        ready_next = ready_reg;
        if (!ready_reg)
        begin
            clr_next = clr_reg + AW'(1);
            if (clr_reg == LAST)
            begin
                ready_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            clr_reg   <= clr_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ready_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (wr_ok)
        begin
            mem[wr_addr] <= wr.value;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = ready_reg;

endmodule

>>> rtl/srpg_motion_core.sv
// Motion state, tick counter and ramp phase machine. Issues one table read per
// accepted item and updates the state when the data returns. Depends on srpg_pkg.
module srpg_motion_core
    import srpg_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF,
    parameter int STEP_BITS  = STEP_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    input  logic                  tbl_ready,
    input  logic                  buf_full,
    output tbl_wr_t               tbl_wr,
    output tbl_rd_t               tbl_rd,
    input  logic [DIV_W-1:0]      rd_data,
    output logic                  push,
    output out_item_t             push_item
);

    localparam int CMPW = (STEP_BITS > ENTRIES_W + 1) ? STEP_BITS : ENTRIES_W + 1;
    localparam int ECAP = (RAMP_DEPTH > (1 << ENTRIES_W) - 1) ? (1 << ENTRIES_W) - 1
                                                              : RAMP_DEPTH;
    localparam logic [ENTRIES_W-1:0] ENTRY_CAP = ENTRIES_W'(ECAP);

    logic                 busy_reg, busy_next;
    in_item_t             item_reg;
    logic [ENTRIES_W-1:0] entries_reg, entries_next;
    logic [DIV_W-1:0]     period_reg, period_next;
    logic [DIV_W-1:0]     tick_reg, tick_next;
    logic [DIV_W-1:0]     rdiv_reg, rdiv_next;
    phase_t               phase_reg, phase_next;
    logic [ENTRIES_W-1:0] pos_reg, pos_next;
    logic [ENTRIES_W-1:0] limit_reg, limit_next;
    logic [STEP_BITS-1:0] steps_reg, steps_next;
    logic [DIV_W-1:0]     cruise_reg, cruise_next;
    logic                 restart_reg, restart_next;
    logic                 pen_reg, pen_next;
    logic                 done_reg, done_next;
    logic                 pin_pulse_reg, pin_pulse_next;
    logic                 pin_dir_reg, pin_dir_next;
    logic                 pin_en_reg, pin_en_next;

    logic                 accept;
    logic                 accel_go;
    logic [ENTRIES_W-1:0] rd_pos;

    assign in_ready = tbl_ready && !busy_reg && !buf_full;
    assign accept   = in_valid && in_ready;
    assign accel_go = (cruise_reg < rdiv_reg) && (pos_reg < limit_reg);

    always_comb
    begin
        priority if (restart_reg || phase_reg == PH_INIT)
        begin
            rd_pos = '0;
        end
        else if (phase_reg == PH_ACCEL && accel_go)
        begin
            rd_pos = pos_reg;
        end
        else if (pos_reg != '0)
        begin
            rd_pos = pos_reg - ENTRIES_W'(1);
        end
        else
        begin
            rd_pos = '0;
        end
    end

    assign tbl_rd.en    = accept;
    assign tbl_rd.pos   = rd_pos;
    assign tbl_wr.en    = busy_reg && item_reg.func == FUNC_TABLE;
    assign tbl_wr.index = item_reg.table_index;
    assign tbl_wr.value = item_reg.table_value;

    always_comb
    begin
        logic [DIV_W-1:0]     tick_inc;
        logic [DIV_W:0]       count17;
        logic [DIV_W:0]       period17;
        logic [DIV_W:0]       half;
        logic [ENTRIES_W-1:0] entries;
        logic [CMPW-1:0]      steps_w;
        logic [CMPW-1:0]      half_steps;
        logic [CMPW-1:0]      pos_w;
        logic                 fin;
        phase_t               ph;

        busy_next      = busy_reg;
        entries_next   = entries_reg;
        period_next    = period_reg;
        tick_next      = tick_reg;
        rdiv_next      = rdiv_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        limit_next     = limit_reg;
        steps_next     = steps_reg;
        cruise_next    = cruise_reg;
        restart_next   = restart_reg;
        pen_next       = pen_reg;
        done_next      = done_reg;
        pin_pulse_next = pin_pulse_reg;
        pin_dir_next   = pin_dir_reg;
        pin_en_next    = pin_en_reg;

        tick_inc   = tick_reg + DIV_W'(1);
        count17    = {tick_inc == '0, tick_inc};
        period17   = {period_reg == '0, period_reg};
        half       = period17 >> 1;
        entries    = (32'(entries_reg) > 32'(RAMP_DEPTH)) ? ENTRY_CAP : entries_reg;
        steps_w    = '0;
        half_steps = '0;
        pos_w      = '0;
        fin        = 1'b0;
        ph         = phase_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end

        if (busy_reg)
        begin
            unique case (item_reg.func)
                FUNC_TICK:
                begin
                    if (pen_reg && count17 <= half)
                    begin
                        pin_pulse_next = 1'b0;
                        tick_next      = tick_inc;
                    end
                    else
                    begin
                        if (pen_reg)
                        begin
                            pin_pulse_next = 1'b1;
                        end
                        if (tick_inc == period_reg)
                        begin
                            tick_next = '0;
                            if (restart_reg)
                            begin
                                pos_next     = '0;
                                ph           = PH_INIT;
                                restart_next = 1'b0;
                            end
                            if (ph == PH_INIT)
                            begin
                                steps_w    = CMPW'(steps_next);
                                half_steps = steps_w >> 1;
                                if (steps_w > CMPW'({entries, 1'b0}))
                                begin
                                    limit_next = entries;
                                end
                                else
                                begin
                                    limit_next = half_steps[ENTRIES_W-1:0];
                                end
                                pos_next  = '0;
                                rdiv_next = rd_data;
                                ph        = PH_ACCEL;
                                if (steps_next != '0)
                                begin
                                    pen_next = 1'b1;
                                end
                            end
                            if (ph == PH_ACCEL)
                            begin
                                if (cruise_next < rdiv_next && pos_next < limit_next)
                                begin
                                    rdiv_next  = rd_data;
                                    steps_next = steps_next - STEP_BITS'(1);
                                    pos_next   = pos_next + ENTRIES_W'(1);
                                    fin        = 1'b1;
                                end
                                else
                                begin
                                    ph = PH_CRUISE;
                                end
                            end
                            if (!fin && ph == PH_CRUISE)
                            begin
                                steps_w = CMPW'(steps_next);
                                pos_w   = CMPW'(pos_next);
                                if (steps_w > pos_w)
                                begin
                                    steps_next = steps_next - STEP_BITS'(1);
                                    fin        = 1'b1;
                                end
                                else
                                begin
                                    ph = PH_DECEL;
                                end
                            end
                            if (!fin && ph == PH_DECEL)
                            begin
                                if (steps_next != '0)
                                begin
                                    steps_next = steps_next - STEP_BITS'(1);
                                    if (pos_next != '0)
                                    begin
                                        pos_next = pos_next - ENTRIES_W'(1);
                                    end
                                    rdiv_next = rd_data;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                    pen_next  = 1'b0;
                                end
                            end
                            phase_next  = ph;
                            period_next = rdiv_next;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                end
                FUNC_START:
                begin
                    steps_next   = STEP_BITS'(item_reg.step_count);
                    cruise_next  = item_reg.target_divisor;
                    pin_dir_next = item_reg.direction;
                    pin_en_next  = 1'b1;
                    done_next    = 1'b0;
                    restart_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP_ENTRIES:    entries_next = cfg_data[ENTRIES_W-1:0];
                REG_INITIAL_DIVISOR: period_next  = cfg_data[DIV_W-1:0];
            endcase
        end
    end

    assign push                      = busy_reg;
    assign push_item.pulse_level     = pin_pulse_next;
    assign push_item.dir_level       = pin_dir_next;
    assign push_item.driver_enable   = pin_en_next;
    assign push_item.motion_done     = done_next;
    assign push_item.current_divisor = period_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            entries_reg   <= ENTRIES_RESET;
            period_reg    <= PERIOD_RESET;
            tick_reg      <= '0;
            rdiv_reg      <= '0;
            phase_reg     <= PH_INIT;
            pos_reg       <= '0;
            limit_reg     <= '0;
            steps_reg     <= '0;
            cruise_reg    <= '0;
            restart_reg   <= 1'b0;
            pen_reg       <= 1'b0;
            done_reg      <= 1'b0;
            pin_pulse_reg <= 1'b1;
            pin_dir_reg   <= 1'b0;
            pin_en_reg    <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            entries_reg   <= entries_next;
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            rdiv_reg      <= rdiv_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            limit_reg     <= limit_next;
            steps_reg     <= steps_next;
            cruise_reg    <= cruise_next;
            restart_reg   <= restart_next;
            pen_reg       <= pen_next;
            done_reg      <= done_next;
            pin_pulse_reg <= pin_pulse_next;
            pin_dir_reg   <= pin_dir_next;
            pin_en_reg    <= pin_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> rtl/srpg_out_buf.sv
// Two-entry result queue between the motion core and the output channel.
// Depends on srpg_pkg.
module srpg_out_buf
    import srpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign full      = cnt_reg == 2'd2;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/stepper_ramp_pulse_generator_core.sv
// Stepper ramp pulse generator: each input transfer is a timer tick, a motion
// start or a ramp table write, and yields one result transfer with the pin
// levels and the period in force. The cycle of an item's transfer issues a read of
// the ramp table memory, and in the next cycle the returned entry completes the
// phase machine step and the result enters a two-entry output queue; no new item
// is taken while one is in flight, nor while the queue is full. After reset a
// clearing pass zeroes the table, during which in_ready stays low; configuration
// writes are taken at any time but belong in idle periods. A divisor of zero
// means 65536 ticks. Depends on srpg_pkg, srpg_table_mem, srpg_motion_core,
// srpg_out_buf.
module stepper_ramp_pulse_generator_core
    import srpg_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF,
    parameter int STEP_BITS  = STEP_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    tbl_wr_t          tbl_wr;
    tbl_rd_t          tbl_rd;
    logic [DIV_W-1:0] rd_data;
    logic             tbl_ready;
    logic             buf_full;
    logic             res_push;
    out_item_t        res_item;

    srpg_table_mem #(
        .RAMP_DEPTH(RAMP_DEPTH)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (tbl_wr),
        .rd     (tbl_rd),
        .rd_data(rd_data),
        .ready  (tbl_ready)
    );

    srpg_motion_core #(
        .RAMP_DEPTH(RAMP_DEPTH),
        .STEP_BITS (STEP_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .tbl_ready(tbl_ready),
        .buf_full (buf_full),
        .tbl_wr   (tbl_wr),
        .tbl_rd   (tbl_rd),
        .rd_data  (rd_data),
        .push     (res_push),
        .push_item(res_item)
    );

    srpg_out_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .push_item(res_item),
        .full     (buf_full),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

`ifndef ASSERT_OFF
    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second transfer was taken while an item was in flight.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> res_push)
        else $error("An accepted item did not produce a result in the next cycle.");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !buf_full)
        else $error("A result was pushed into a full output queue.");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_ready |-> !in_ready)
        else $error("Input was accepted during the table clearing pass.");
`endif

endmodule
